>>> design/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg
// shared types, request codes and sizes of the picture reorder buffer
// ----------------------------------------------------------------------------
package frb_pkg;

   localparam int MAX_SLOTS  = 32;
   localparam int HOLD_DEPTH = 6;
   localparam int SLOT_W     = 5;
   localparam int CNT_W      = 6;
   localparam int HCNT_W     = 3;

   localparam logic [CNT_W-1:0] CAP_RESET = 6'd24;
   localparam logic [CNT_W-1:0] CAP_MIN   = 6'd2;

   localparam logic [2:0] REQ_ACQUIRE = 3'd0;
   localparam logic [2:0] REQ_PUSH    = 3'd1;
   localparam logic [2:0] REQ_POP     = 3'd2;
   localparam logic [2:0] REQ_CONSUME = 3'd3;
   localparam logic [2:0] REQ_CLEAR   = 3'd4;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [63:0]        pts_us;
      logic signed [31:0] dur_us;
      logic               has_order;
      logic [31:0]        pic_order;
      logic [30:0]        consume_us;
   } req_pkt_type;

   typedef struct packed {
      logic               write_valid;
      logic [4:0]         write_slot;
      logic [4:0]         head_slot;
      logic [63:0]        front_pts;
      logic signed [31:0] front_dur;
      logic [31:0]        front_seq;
      logic [4:0]         second_slot;
      logic signed [31:0] second_dur;
      logic [5:0]         ring_count;
      logic [5:0]         used_count;
      logic               buffer_full;
   } rsp_pkt_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_ACQ_RD, ST_ACQ_WR, ST_PUSH, ST_EVICT, ST_INSERT, ST_FLUSH,
      ST_APPEND, ST_POP_RD, ST_CON_RD, ST_CON_DUR, ST_CON_WR, ST_RETIRE,
      ST_CLEAR, ST_OUT_RING, ST_OUT_SLOT, ST_OUT
   } st_type;

   typedef struct packed {
      logic               pts_en;
      logic               dur_en;
      logic               seq_en;
      logic [SLOT_W-1:0]  pd_addr;
      logic [SLOT_W-1:0]  seq_addr;
      logic [63:0]        pts;
      logic signed [31:0] dur;
      logic [31:0]        seq;
   } slot_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr_a;
      logic [SLOT_W-1:0] addr_b;
   } rd2_type;

   typedef struct packed {
      logic [63:0]        pts;
      logic signed [31:0] dur_a;
      logic [31:0]        seq;
      logic signed [31:0] dur_b;
   } slot_q_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [SLOT_W-1:0] slot;
   } idx_wr_type;

   typedef struct packed {
      logic [SLOT_W-1:0] a;
      logic [SLOT_W-1:0] b;
   } ring_q_type;

endpackage

>>> design/frb_slot_store.sv
// ----------------------------------------------------------------------------
// frb_slot_store
// per-slot pts, duration and sequence memory, two registered read ports
// ----------------------------------------------------------------------------
module frb_slot_store (
   input  logic               clock,
   input  frb_pkg::slot_wr_type wr,
   input  frb_pkg::rd2_type   rd,
   output frb_pkg::slot_q_type q
);
   import frb_pkg::*;

   logic [63:0] pts_mem [MAX_SLOTS];
   logic [31:0] dur_mem [MAX_SLOTS];
   logic [31:0] seq_mem [MAX_SLOTS];
   slot_q_type  q_ff;

   always_ff @(posedge clock) begin
      if (wr.pts_en) pts_mem[wr.pd_addr] <= wr.pts;
      if (wr.dur_en) dur_mem[wr.pd_addr] <= wr.dur;
      if (wr.seq_en) seq_mem[wr.seq_addr] <= wr.seq;
      if (rd.en) begin
         q_ff.pts   <= pts_mem[rd.addr_a];
         q_ff.dur_a <= dur_mem[rd.addr_a];
         q_ff.seq   <= seq_mem[rd.addr_a];
         q_ff.dur_b <= dur_mem[rd.addr_b];
      end
   end

   assign q = q_ff;
endmodule

>>> design/frb_ring_store.sv
// ----------------------------------------------------------------------------
// frb_ring_store
// display ring of slot indexes, one write port and two registered reads
// ----------------------------------------------------------------------------
module frb_ring_store (
   input  logic                clock,
   input  frb_pkg::idx_wr_type wr,
   input  frb_pkg::rd2_type    rd,
   output frb_pkg::ring_q_type q
);
   import frb_pkg::*;

   logic [SLOT_W-1:0] ring_mem [MAX_SLOTS];
   ring_q_type        q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) ring_mem[wr.addr] <= wr.slot;
      if (rd.en) begin
         q_ff.a <= ring_mem[rd.addr_a];
         q_ff.b <= ring_mem[rd.addr_b];
      end
   end

   assign q = q_ff;
endmodule

>>> design/frb_free_stack.sv
// ----------------------------------------------------------------------------
// frb_free_stack
// free-slot stack memory; entries not written since clear read as cap-1-pos
// ----------------------------------------------------------------------------
module frb_free_stack (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic [frb_pkg::CNT_W-1:0]   cap,
   input  frb_pkg::idx_wr_type         wr,
   input  logic                        rd_en,
   input  logic [frb_pkg::SLOT_W-1:0]  rd_addr,
   output logic [frb_pkg::SLOT_W-1:0]  rd_slot
);
   import frb_pkg::*;

   logic [SLOT_W-1:0]    stack_mem [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] valid_ff;
   logic [SLOT_W-1:0]    q_ff;
   logic [SLOT_W-1:0]    dflt_ff;
   logic                 qv_ff;
   logic [CNT_W-1:0]     dflt_in;

   assign dflt_in = cap - CNT_W'(1) - {1'b0, rd_addr};

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) stack_mem[wr.addr] <= wr.slot;
      if (rd_en) begin
         q_ff    <= stack_mem[rd_addr];
         qv_ff   <= valid_ff[rd_addr];
         dflt_ff <= dflt_in[SLOT_W-1:0];
      end
   end

   assign rd_slot = qv_ff ? q_ff : dflt_ff;
endmodule

>>> design/frame_reorder_jitter_buffer_top.sv
// ----------------------------------------------------------------------------
// frame_reorder_jitter_buffer_top
// frame-slot manager and picture reorder buffer for a video decoder
// ----------------------------------------------------------------------------
// One request is worked at a time and returns one result. The sequencer
// reads and writes the slot, ring and free-stack memories one step per
// cycle, and every hold release moves one picture into the ring per cycle;
// when a push finds the hold full, its lowest picture leaves first.
// A new request is taken while the previous result still waits in the
// output register; a stalled result holds the next one in its last step. The
// capacity register takes effect at reset and at a clear request; no clearing
// pass is needed after reset.
module frame_reorder_jitter_buffer_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  frb_pkg::req_pkt_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output frb_pkg::rsp_pkt_type  rsp_data,
   input  logic                  csr_wr_en,
   input  logic [5:0]            csr_wr_data
);
   import frb_pkg::*;

   st_type            state_ff, state_in;
   req_pkt_type       req_ff, req_in;
   logic [CNT_W-1:0]  cap_reg_ff;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  fc_ff, fc_in;
   logic [SLOT_W-1:0] wslot_ff, wslot_in;
   logic              held_ff, held_in;
   logic [SLOT_W-1:0] rp_ff, rp_in, wp_ff, wp_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SLOT_W-1:0] hslot_ff [HOLD_DEPTH];
   logic [SLOT_W-1:0] hslot_in [HOLD_DEPTH];
   logic [31:0]       hord_ff [HOLD_DEPTH];
   logic [31:0]       hord_in [HOLD_DEPTH];
   logic [HCNT_W-1:0] hfill_ff, hfill_in;
   logic [31:0]       max_ff, max_in;
   logic              seen_ff, seen_in;
   logic [31:0]       seq_ff, seq_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [31:0]       limit_ff, limit_in;
   logic              tail_ff, tail_in;
   logic [SLOT_W-1:0] pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_pkt_type       rsp_ff, rsp_in;

   slot_wr_type       slot_wr;
   rd2_type           slot_rd;
   slot_q_type        slot_q;
   idx_wr_type        ring_wr;
   rd2_type           ring_rd;
   ring_q_type        ring_q;
   idx_wr_type        fs_wr;
   logic              fs_rd_en;
   logic [SLOT_W-1:0] fs_rd_addr;
   logic [SLOT_W-1:0] fs_slot;
   logic              fs_clear;

   // shared decisions
   logic [HCNT_W-1:0] hmax;
   logic              evict;
   logic              flush_go;
   logic [HCNT_W-1:0] ins_at;
   logic signed [32:0] con_d;
   logic              con_le0;
   logic              con_sat;
   logic [CNT_W-1:0]  cap_clamp;
   logic [SLOT_W-1:0] rp_next;
   logic [CNT_W-1:0]  rp_inc;
   logic              out_load;
   logic              do_app;
   logic [SLOT_W-1:0] app_slot;
   logic              app_ok;

   assign hmax = (cap_ff[CNT_W-1:1] > 5'(HOLD_DEPTH)) ? HCNT_W'(HOLD_DEPTH)
                                                       : cap_ff[HCNT_W:1];
   assign evict    = (hfill_ff >= hmax) && (hfill_ff != '0);
   assign flush_go = (hfill_ff != '0) && (hord_ff[0] <= limit_ff);

   always_comb begin
      ins_at = '0;
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if ((HCNT_W'(i) < hfill_ff) && (hord_ff[i] <= req_ff.pic_order))
            ins_at = ins_at + HCNT_W'(1);
      end
   end

   assign con_d   = {slot_q.dur_a[31], slot_q.dur_a} - $signed({2'b00, req_ff.consume_us});
   assign con_sat = con_d[32] & ~con_d[31];
   assign con_le0 = con_d[32] | (con_d == '0);

   assign cap_clamp = (cap_reg_ff < CAP_MIN) ? CAP_MIN :
                      (cap_reg_ff > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cap_reg_ff;

   assign rp_inc  = {1'b0, rp_ff} + CNT_W'(1);
   assign rp_next = (rp_inc == cap_ff) ? '0 : rp_inc[SLOT_W-1:0];
   assign out_load = (state_ff == ST_OUT) && !(rsp_valid_ff && rsp_stall);
   assign app_ok  = fill_ff < cap_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority case (req_data.req_type)
                  REQ_ACQUIRE: state_in = (!held_ff && fc_ff != '0) ? ST_ACQ_RD : ST_OUT_RING;
                  REQ_PUSH:    state_in = held_ff ? ST_PUSH : ST_OUT_RING;
                  REQ_POP:     state_in = (fill_ff != '0) ? ST_POP_RD : ST_OUT_RING;
                  REQ_CONSUME: state_in = (fill_ff != '0) ? ST_CON_RD : ST_OUT_RING;
                  REQ_CLEAR:   state_in = ST_CLEAR;
                  default:     state_in = ST_OUT_RING;
               endcase
            end
         end
         ST_ACQ_RD:  state_in = ST_ACQ_WR;
         ST_ACQ_WR:  state_in = ST_OUT_RING;
         ST_PUSH: begin
            if (!req_ff.has_order) state_in = seen_ff ? ST_FLUSH : ST_APPEND;
            else                   state_in = evict ? ST_EVICT : ST_INSERT;
         end
         ST_EVICT:   state_in = ST_INSERT;
         ST_INSERT: begin
            if (seen_ff && req_ff.pic_order > max_ff) state_in = ST_FLUSH;
            else                                       state_in = ST_OUT_RING;
         end
         ST_FLUSH: begin
            if (!flush_go) state_in = tail_ff ? ST_APPEND : ST_OUT_RING;
         end
         ST_APPEND:   state_in = ST_OUT_RING;
         ST_POP_RD:   state_in = ST_RETIRE;
         ST_CON_RD:   state_in = ST_CON_DUR;
         ST_CON_DUR:  state_in = ST_CON_WR;
         ST_CON_WR:   state_in = con_le0 ? ST_RETIRE : ST_OUT_RING;
         ST_RETIRE:   state_in = ST_OUT_RING;
         ST_CLEAR:    state_in = ST_OUT_RING;
         ST_OUT_RING: state_in = ST_OUT_SLOT;
         ST_OUT_SLOT: state_in = ST_OUT;
         ST_OUT:      state_in = out_load ? ST_IDLE : ST_OUT;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in   = req_ff;
      cap_in   = cap_ff;
      fc_in    = fc_ff;
      wslot_in = wslot_ff;
      held_in  = held_ff;
      rp_in    = rp_ff;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      hslot_in = hslot_ff;
      hord_in  = hord_ff;
      hfill_in = hfill_ff;
      max_in   = max_ff;
      seen_in  = seen_ff;
      seq_in   = seq_ff;
      used_in  = used_ff;
      limit_in = limit_ff;
      tail_in  = tail_ff;
      pend_in  = pend_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      slot_wr  = '0;
      slot_rd  = '0;
      ring_wr  = '0;
      ring_rd  = '0;
      fs_wr    = '0;
      fs_rd_en = 1'b0;
      fs_rd_addr = '0;
      fs_clear = 1'b0;
      do_app   = 1'b0;
      app_slot = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) req_in = req_data;
         end
         ST_ACQ_RD: begin
            fs_rd_en   = 1'b1;
            fs_rd_addr = 5'(fc_ff - CNT_W'(1));
         end
         ST_ACQ_WR: begin
            wslot_in = fs_slot;
            held_in  = 1'b1;
            fc_in    = fc_ff - CNT_W'(1);
            used_in  = cap_ff - fc_in;
         end
         ST_PUSH: begin
            slot_wr.pts_en  = 1'b1;
            slot_wr.dur_en  = 1'b1;
            slot_wr.pd_addr = wslot_ff;
            slot_wr.pts     = req_ff.pts_us;
            slot_wr.dur     = req_ff.dur_us;
            pend_in  = wslot_ff;
            held_in  = 1'b0;
            wslot_in = '0;
            tail_in  = !req_ff.has_order;
            limit_in = max_ff;
         end
         ST_EVICT: begin
            do_app   = 1'b1;
            app_slot = hslot_ff[0];
            for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
               hslot_in[i] = hslot_ff[i+1];
               hord_in[i]  = hord_ff[i+1];
            end
            hfill_in = hfill_ff - HCNT_W'(1);
         end
         ST_INSERT: begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               if (HCNT_W'(i) == ins_at) begin
                  hslot_in[i] = pend_ff;
                  hord_in[i]  = req_ff.pic_order;
               end else if (HCNT_W'(i) > ins_at && i > 0) begin
                  hslot_in[i] = hslot_ff[i-1];
                  hord_in[i]  = hord_ff[i-1];
               end
            end
            hfill_in = hfill_ff + HCNT_W'(1);
            if (!seen_ff) begin
               seen_in = 1'b1;
               max_in  = req_ff.pic_order;
            end else if (req_ff.pic_order > max_ff) begin
               limit_in = max_ff;
               max_in   = req_ff.pic_order;
            end
         end
         ST_FLUSH: begin
            if (flush_go) begin
               do_app   = 1'b1;
               app_slot = hslot_ff[0];
               for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                  hslot_in[i] = hslot_ff[i+1];
                  hord_in[i]  = hord_ff[i+1];
               end
               hfill_in = hfill_ff - HCNT_W'(1);
            end
         end
         ST_APPEND: begin
            do_app   = 1'b1;
            app_slot = pend_ff;
         end
         ST_POP_RD, ST_CON_RD: begin
            ring_rd.en     = 1'b1;
            ring_rd.addr_a = rp_ff;
            ring_rd.addr_b = rp_ff;
         end
         ST_CON_DUR: begin
            slot_rd.en     = 1'b1;
            slot_rd.addr_a = ring_q.a;
            slot_rd.addr_b = ring_q.a;
         end
         ST_CON_WR: begin
            slot_wr.dur_en  = 1'b1;
            slot_wr.pd_addr = ring_q.a;
            slot_wr.dur     = con_sat ? 32'sh8000_0000 : con_d[31:0];
         end
         ST_RETIRE: begin
            rp_in   = rp_next;
            fill_in = fill_ff - CNT_W'(1);
            if (fc_ff < CNT_W'(MAX_SLOTS)) begin
               fs_wr.en   = 1'b1;
               fs_wr.addr = fc_ff[SLOT_W-1:0];
               fs_wr.slot = ring_q.a;
               fc_in      = fc_ff + CNT_W'(1);
            end
            used_in = cap_ff - fc_in;
         end
         ST_CLEAR: begin
            cap_in   = cap_clamp;
            fc_in    = cap_clamp;
            fs_clear = 1'b1;
            wslot_in = '0;
            held_in  = 1'b0;
            rp_in    = '0;
            wp_in    = '0;
            fill_in  = '0;
            hfill_in = '0;
            max_in   = '0;
            seen_in  = 1'b0;
            used_in  = '0;
         end
         ST_OUT_RING: begin
            ring_rd.en     = 1'b1;
            ring_rd.addr_a = rp_ff;
            ring_rd.addr_b = rp_next;
         end
         ST_OUT_SLOT: begin
            slot_rd.en     = 1'b1;
            slot_rd.addr_a = ring_q.a;
            slot_rd.addr_b = ring_q.b;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.write_valid = held_ff;
               rsp_in.write_slot  = held_ff ? wslot_ff : '0;
               if (fill_ff != '0) begin
                  rsp_in.head_slot  = ring_q.a;
                  rsp_in.front_pts  = slot_q.pts;
                  rsp_in.front_dur  = slot_q.dur_a;
                  rsp_in.front_seq  = slot_q.seq;
               end
               if (fill_ff > CNT_W'(1)) begin
                  rsp_in.second_slot = ring_q.b;
                  rsp_in.second_dur  = slot_q.dur_b;
               end
               rsp_in.ring_count  = fill_ff;
               rsp_in.used_count  = used_ff;
               rsp_in.buffer_full = (fc_ff == '0) && !held_ff;
            end
         end
         default: begin
         end
      endcase

      // ring append: stamp a sequence number and write the ring tail
      if (do_app && app_ok) begin
         seq_in           = seq_ff + 32'd1;
         slot_wr.seq_en   = 1'b1;
         slot_wr.seq_addr = app_slot;
         slot_wr.seq      = seq_in;
         ring_wr.en       = 1'b1;
         ring_wr.addr     = wp_ff;
         ring_wr.slot     = app_slot;
         wp_in   = (({1'b0, wp_ff} + CNT_W'(1)) == cap_ff) ? '0 : wp_ff + SLOT_W'(1);
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_reg_ff   <= CAP_RESET;
         cap_ff       <= CAP_RESET;
         fc_ff        <= CAP_RESET;
         wslot_ff     <= '0;
         held_ff      <= 1'b0;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         hfill_ff     <= '0;
         max_ff       <= '0;
         seen_ff      <= 1'b0;
         seq_ff       <= '0;
         used_ff      <= '0;
         tail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) cap_reg_ff <= csr_wr_data;
         cap_ff       <= cap_in;
         fc_ff        <= fc_in;
         wslot_ff     <= wslot_in;
         held_ff      <= held_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         hfill_ff     <= hfill_in;
         max_ff       <= max_in;
         seen_ff      <= seen_in;
         seq_ff       <= seq_in;
         used_ff      <= used_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      hslot_ff <= hslot_in;
      hord_ff  <= hord_in;
      limit_ff <= limit_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   frb_slot_store u_slot (
      .clock (clock),
      .wr    (slot_wr),
      .rd    (slot_rd),
      .q     (slot_q)
   );

   frb_ring_store u_ring (
      .clock (clock),
      .wr    (ring_wr),
      .rd    (ring_rd),
      .q     (ring_q)
   );

   frb_free_stack u_free (
      .clock   (clock),
      .reset   (reset),
      .clear   (fs_clear),
      .cap     (cap_ff),
      .wr      (fs_wr),
      .rd_en   (fs_rd_en),
      .rd_addr (fs_rd_addr),
      .rd_slot (fs_slot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // slots never multiply: free, held, in the hold and in the ring fit in capacity
   assert property (@(posedge clock) disable iff (reset)
      (7'(fc_ff) + 7'(held_ff) + 7'(hfill_ff) + 7'(fill_ff)) <= 7'(cap_ff))
      else $error("slot accounting exceeds capacity");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= cap_ff) && (hfill_ff <= HCNT_W'(HOLD_DEPTH)))
      else $error("ring or hold overfilled");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside output step");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RETIRE) |-> (fill_ff != '0))
      else $error("retire on empty ring");

endmodule

>>> dv/frame_reorder_jitter_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// frame_reorder_jitter_buffer_top_tb
// self-checking bench: predicts every result of the reorder buffer from its
// own model of the slot stack, hold and display ring, and compares in order
// ----------------------------------------------------------------------------
class reorder_scoreboard;

   bit [5:0]         cap_reg;
   int unsigned      cap_now;
   bit [4:0]         free_stk[32];
   int unsigned      free_n;
   bit [4:0]         wr_slot;
   bit               wr_held;
   bit [4:0]         ring[32];
   int unsigned      rd_pos, wr_pos, ring_n;
   bit [4:0]         hold_slot[6];
   bit [31:0]        hold_ord[6];
   int unsigned      hold_n;
   bit [31:0]        top_ord;
   bit               top_seen;
   bit [63:0]        pic_pts[32];
   bit signed [31:0] pic_dur[32];
   bit [31:0]        pic_seq[32];
   bit [31:0]        seq_num;
   int unsigned      used_n;
   frb_pkg::rsp_pkt_type expected_q[$];
   int               errors;
   int               checked;

   function new();
      cap_reg = frb_pkg::CAP_RESET;
      seq_num = 0;
      errors = 0;
      checked = 0;
      restart();
   endfunction

   function void restart();
      cap_now = cap_reg < 2 ? 2 : (cap_reg > 32 ? 32 : cap_reg);
      free_n = 0;
      for (int i = cap_now; i > 0; i--) begin
         free_stk[free_n] = 5'(i - 1);
         free_n++;
      end
      wr_slot = 0;
      wr_held = 0;
      rd_pos = 0;
      wr_pos = 0;
      ring_n = 0;
      hold_n = 0;
      top_ord = 0;
      top_seen = 0;
      used_n = 0;
   endfunction

   function void to_ring(bit [4:0] s);
      if (ring_n >= cap_now) return;
      seq_num++;
      pic_seq[s] = seq_num;
      ring[wr_pos] = s;
      wr_pos = (wr_pos + 1) % cap_now;
      ring_n++;
   endfunction

   function void retire();
      free_stk[free_n] = ring[rd_pos];
      free_n++;
      rd_pos = (rd_pos + 1) % cap_now;
      ring_n--;
      used_n = cap_now - free_n;
   endfunction

   function void hold_shift(int unsigned n);
      for (int i = n; i < hold_n; i++) begin
         hold_slot[i-n] = hold_slot[i];
         hold_ord[i-n] = hold_ord[i];
      end
      hold_n -= n;
   endfunction

   function void release_upto(bit [31:0] lim);
      int unsigned n;
      n = 0;
      while (n < hold_n && hold_ord[n] <= lim) n++;
      for (int i = 0; i < n; i++) to_ring(hold_slot[i]);
      hold_shift(n);
   endfunction

   function void push(frb_pkg::req_pkt_type r);
      bit [4:0] s;
      int unsigned at, hmax;
      bit [31:0] prev;
      if (!wr_held) return;
      s = wr_slot;
      wr_held = 0;
      wr_slot = 0;
      pic_pts[s] = r.pts_us;
      pic_dur[s] = r.dur_us;
      if (!r.has_order) begin
         if (top_seen) release_upto(top_ord);
         to_ring(s);
         return;
      end
      hmax = cap_now / 2 > 6 ? 6 : cap_now / 2;
      if (hold_n >= hmax && hold_n > 0) begin
         to_ring(hold_slot[0]);
         hold_shift(1);
      end
      at = hold_n;
      while (at > 0 && hold_ord[at-1] > r.pic_order) begin
         hold_slot[at] = hold_slot[at-1];
         hold_ord[at] = hold_ord[at-1];
         at--;
      end
      hold_slot[at] = s;
      hold_ord[at] = r.pic_order;
      hold_n++;
      if (!top_seen) begin
         top_seen = 1;
         top_ord = r.pic_order;
      end else if (r.pic_order > top_ord) begin
         prev = top_ord;
         top_ord = r.pic_order;
         release_upto(prev);
      end
   endfunction

   function void note_request(frb_pkg::req_pkt_type r);
      frb_pkg::rsp_pkt_type e;
      longint d;
      bit [4:0] f;
      case (r.req_type)
         frb_pkg::REQ_ACQUIRE: begin
            if (!wr_held && free_n > 0) begin
               free_n--;
               wr_slot = free_stk[free_n];
               wr_held = 1;
               used_n = cap_now - free_n;
            end
         end
         frb_pkg::REQ_PUSH: push(r);
         frb_pkg::REQ_POP: if (ring_n > 0) retire();
         frb_pkg::REQ_CONSUME: begin
            if (ring_n > 0) begin
               f = ring[rd_pos];
               d = longint'(pic_dur[f]) - longint'(r.consume_us);
               if (d < -64'sd2147483648) d = -64'sd2147483648;
               pic_dur[f] = d[31:0];
               if (d <= 0) retire();
            end
         end
         frb_pkg::REQ_CLEAR: restart();
         default: ;
      endcase
      e = '0;
      e.write_valid = wr_held;
      e.write_slot = wr_held ? wr_slot : 5'd0;
      if (ring_n > 0) begin
         f = ring[rd_pos];
         e.head_slot = f;
         e.front_pts = pic_pts[f];
         e.front_dur = pic_dur[f];
         e.front_seq = pic_seq[f];
      end
      if (ring_n > 1) begin
         f = ring[(rd_pos + 1) % cap_now];
         e.second_slot = f;
         e.second_dur = pic_dur[f];
      end
      e.ring_count = 6'(ring_n);
      e.used_count = 6'(used_n);
      e.buffer_full = (free_n == 0 && !wr_held);
      expected_q.push_back(e);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %0d: %s got %0h want %0h", checked, what, got, want);
   endtask

   task check_result(frb_pkg::rsp_pkt_type g);
      frb_pkg::rsp_pkt_type e;
      checked++;
      if (expected_q.size() == 0) begin
         report("unexpected result", 0, 0);
         return;
      end
      e = expected_q.pop_front();
      if (g.write_valid !== e.write_valid) report("write_valid", g.write_valid, e.write_valid);
      if (g.write_slot !== e.write_slot) report("write_slot", g.write_slot, e.write_slot);
      if (g.head_slot !== e.head_slot) report("head_slot", g.head_slot, e.head_slot);
      if (g.front_pts !== e.front_pts) report("front_pts", g.front_pts, e.front_pts);
      if (g.front_dur !== e.front_dur) report("front_dur", g.front_dur, e.front_dur);
      if (g.front_seq !== e.front_seq) report("front_seq", g.front_seq, e.front_seq);
      if (g.second_slot !== e.second_slot) report("second_slot", g.second_slot, e.second_slot);
      if (g.second_dur !== e.second_dur) report("second_dur", g.second_dur, e.second_dur);
      if (g.ring_count !== e.ring_count) report("ring_count", g.ring_count, e.ring_count);
      if (g.used_count !== e.used_count) report("used_count", g.used_count, e.used_count);
      if (g.buffer_full !== e.buffer_full) report("buffer_full", g.buffer_full, e.buffer_full);
   endtask

endclass

module frame_reorder_jitter_buffer_top_tb;
   import frb_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_pkt_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_pkt_type rsp_data;
   logic        csr_wr_en;
   logic [5:0]  csr_wr_data;

   reorder_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_off_cycles;
   int sent;
   bit [31:0] next_order;

   frame_reorder_jitter_buffer_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #60000000;
      $display("tb: failure");
      $finish;
   end

   // receiver: random stall plus an optional long hold-off
   initial begin
      rsp_stall = 1;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // checks each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   task send(req_pkt_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      sent++;
   endtask

   task go_idle();
      req_valid <= 0;
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_capacity(bit [5:0] v);
      go_idle();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.cap_reg = v;
   endtask

   function req_pkt_type rand_req(bit [2:0] t);
      req_pkt_type r;
      r.req_type = t;
      r.pts_us = {$urandom, $urandom};
      r.dur_us = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40000, 1);
      r.has_order = ($urandom_range(7) != 0);
      r.pic_order = ($urandom_range(9) == 0) ? $urandom : next_order + $urandom_range(6);
      r.consume_us = ($urandom_range(5) == 0) ? 31'($urandom) : 31'($urandom_range(30000));
      return r;
   endfunction

   // acquire then push: the well-formed decoder sequence
   task picture();
      req_pkt_type r;
      r = rand_req(REQ_ACQUIRE);
      send(r);
      r = rand_req(REQ_PUSH);
      send(r);
      if ($urandom_range(3) != 0) next_order += $urandom_range(3);
   endtask

   task random_phase(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 45) picture();
         else if (k < 65) send(rand_req(REQ_POP));
         else if (k < 88) send(rand_req(REQ_CONSUME));
         else if (k < 92) send(rand_req(REQ_CLEAR));
         else if (k < 96) send(rand_req(3'($urandom_range(7))));
         else send(rand_req(3'($urandom_range(7, 5))));
      end
   endtask

   task directed();
      req_pkt_type r;
      send(rand_req(REQ_POP));
      send(rand_req(REQ_CONSUME));
      r = rand_req(REQ_PUSH);
      send(r);
      // unkeyed picture before any keyed one
      r = rand_req(REQ_ACQUIRE); send(r);
      send(r);
      r = rand_req(REQ_PUSH);
      r.has_order = 0; r.pts_us = '1; r.dur_us = 32'sh7fffffff;
      send(r);
      // equal keys and extreme keys
      for (int i = 0; i < 4; i++) begin
         send(rand_req(REQ_ACQUIRE));
         r = rand_req(REQ_PUSH);
         r.has_order = 1;
         r.pic_order = (i < 2) ? 32'd5 : (i == 2 ? 32'hffffffff : 32'd0);
         r.dur_us = (i == 3) ? 32'sh80000000 : 32'sd10;
         r.pts_us = (i == 0) ? 64'd0 : {$urandom, $urandom};
         send(r);
      end
      r = rand_req(REQ_CONSUME); r.consume_us = '1; send(r);
      r = rand_req(REQ_CONSUME); r.consume_us = '1; send(r);
      r = rand_req(REQ_CONSUME); r.consume_us = 0; send(r);
      send(rand_req(REQ_POP));
      r = rand_req(3'd5); send(r);
      r = rand_req(3'd7); send(r);
      // flush of the hold by an unkeyed picture
      send(rand_req(REQ_ACQUIRE));
      r = rand_req(REQ_PUSH); r.has_order = 0; send(r);
      send(rand_req(REQ_CLEAR));
   endtask

   initial begin
      sb = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_wr_en = 0;
      csr_wr_data = '0;
      send_idle_pct = 32;
      recv_idle_pct = 49;
      hold_off_cycles = 0;
      sent = 0;
      next_order = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed();

      // capacity written without a clear is held until the clear
      write_capacity(6'd2);
      random_phase(60);
      send(rand_req(REQ_CLEAR));
      random_phase(150);

      // long receiver hold-off while the sender keeps going
      hold_off_cycles = 400;
      random_phase(60);

      write_capacity(6'd32);
      send(rand_req(REQ_CLEAR));
      send_idle_pct = 49;
      recv_idle_pct = 32;
      random_phase(300);

      write_capacity(6'd63);
      send(rand_req(REQ_CLEAR));
      random_phase(150);

      write_capacity(6'd0);
      send(rand_req(REQ_CLEAR));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(120);

      write_capacity(6'd13);
      send(rand_req(REQ_CLEAR));
      random_phase(200);

      req_valid <= 0;
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("covered %0d requests, %0d results checked, capacities 0 to 63",
               sent, sb.checked);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
